FILE: rtl/core/dts_pkg.sv
// Shared constants, opcode codes and control struct for the DFS topological sort unit.
package dts_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int VTX_W = 5;
	localparam int OP_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_SORT  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// Walker to order buffer: sort start, one finished vertex, search done.
	typedef struct packed {
		logic             start;
		logic             fin_valid;
		logic [VTX_W-1:0] fin_vertex;
		logic             done;
	} dts_ctl_t;

endpackage

FILE: rtl/core/dts_adj.sv
// Adjacency bit matrix: one row of successor bits per source vertex.
module dts_adj (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 add_en,
	input  logic                                 clear_en,
	input  logic [dts_pkg::VTX_W-1:0]            from_vertex,
	input  logic [dts_pkg::VTX_W-1:0]            to_vertex,
	input  logic [dts_pkg::VIDX_W-1:0]           rd_addr,
	output logic [dts_pkg::MAX_VERTICES-1:0]     rd_row
);

	logic [dts_pkg::MAX_VERTICES-1:0] rows_q [dts_pkg::MAX_VERTICES];
	logic [dts_pkg::VTX_W-1:0] from_m1;
	logic [dts_pkg::VTX_W-1:0] to_m1;
	logic from_ok;
	logic to_ok;

	assign from_m1 = from_vertex - dts_pkg::VTX_W'(1);
	assign to_m1 = to_vertex - dts_pkg::VTX_W'(1);
	// drop edges with an end outside 1..MAX_VERTICES
	assign from_ok = (from_vertex != '0) &&
		(from_vertex <= dts_pkg::VTX_W'(dts_pkg::MAX_VERTICES));
	assign to_ok = (to_vertex != '0) &&
		(to_vertex <= dts_pkg::VTX_W'(dts_pkg::MAX_VERTICES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dts_pkg::MAX_VERTICES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (clear_en) begin
			for (int i = 0; i < dts_pkg::MAX_VERTICES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (add_en && from_ok && to_ok) begin
			rows_q[from_m1[dts_pkg::VIDX_W-1:0]][to_m1[dts_pkg::VIDX_W-1:0]] <= 1'b1;
		end
	end

	assign rd_row = rows_q[rd_addr];

endmodule

FILE: rtl/core/dts_walker.sv
// DFS sequencer: explicit stack, visited marks, one neighbor test per cycle.
module dts_walker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [dts_pkg::VTX_W-1:0]            vertex_limit,
	input  logic [dts_pkg::MAX_VERTICES-1:0]     adj_row,
	output logic [dts_pkg::VIDX_W-1:0]           adj_addr,
	output dts_pkg::dts_ctl_t                    ctl,
	output logic                                 idle
);

	typedef enum logic [2:0] {
		W_IDLE = 3'b001,
		W_ROOT = 3'b010,
		W_SCAN = 3'b100
	} walk_state_t;

	walk_state_t state_q;
	logic [dts_pkg::VTX_W-1:0] root_q;
	logic [dts_pkg::VTX_W-1:0] depth_q;
	logic [dts_pkg::VTX_W-1:0] w_q;
	logic [dts_pkg::MAX_VERTICES-1:0] visited_q;
	logic [dts_pkg::VTX_W-1:0] stk_v_q [dts_pkg::MAX_VERTICES];
	logic [dts_pkg::VTX_W-1:0] stk_n_q [dts_pkg::MAX_VERTICES];

	logic [dts_pkg::VTX_W-1:0] top_m;
	logic [dts_pkg::VTX_W-1:0] pop_m;
	logic [dts_pkg::VTX_W-1:0] v_m1;
	logic [dts_pkg::VTX_W-1:0] w_m1;
	logic [dts_pkg::VTX_W-1:0] root_m1;
	logic [dts_pkg::VTX_W-1:0] cur_v;
	logic scan_end;
	logic hit;

	assign top_m = depth_q - dts_pkg::VTX_W'(1);
	assign pop_m = depth_q - dts_pkg::VTX_W'(2);
	assign cur_v = stk_v_q[top_m[dts_pkg::VIDX_W-1:0]];
	assign v_m1 = cur_v - dts_pkg::VTX_W'(1);
	assign w_m1 = w_q - dts_pkg::VTX_W'(1);
	assign root_m1 = root_q - dts_pkg::VTX_W'(1);
	assign adj_addr = v_m1[dts_pkg::VIDX_W-1:0];
	assign scan_end = (w_q > vertex_limit);
	assign hit = adj_row[w_m1[dts_pkg::VIDX_W-1:0]] &&
		!visited_q[w_m1[dts_pkg::VIDX_W-1:0]];

	always_comb begin
		ctl = '0;
		ctl.start = start && (state_q == W_IDLE);
		ctl.fin_vertex = cur_v;
		ctl.fin_valid = (state_q == W_SCAN) && scan_end;
		ctl.done = (state_q == W_ROOT) && (root_q > vertex_limit);
	end

	assign idle = (state_q == W_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			root_q <= '0;
			depth_q <= '0;
			w_q <= '0;
			visited_q <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (start) begin
						visited_q <= '0;
						root_q <= dts_pkg::VTX_W'(1);
						state_q <= W_ROOT;
					end
				end
				W_ROOT: begin
					if (root_q > vertex_limit) begin
						state_q <= W_IDLE;
					end else if (visited_q[root_m1[dts_pkg::VIDX_W-1:0]]) begin
						root_q <= root_q + dts_pkg::VTX_W'(1);
					end else begin
						// open a new tree at this root
						visited_q[root_m1[dts_pkg::VIDX_W-1:0]] <= 1'b1;
						depth_q <= dts_pkg::VTX_W'(1);
						w_q <= dts_pkg::VTX_W'(1);
						state_q <= W_SCAN;
					end
				end
				W_SCAN: begin
					if (scan_end) begin
						// all children done: pop, resume parent where it left off
						depth_q <= top_m;
						if (depth_q == dts_pkg::VTX_W'(1)) begin
							root_q <= root_q + dts_pkg::VTX_W'(1);
							state_q <= W_ROOT;
						end else begin
							w_q <= stk_n_q[pop_m[dts_pkg::VIDX_W-1:0]];
						end
					end else if (hit) begin
						visited_q[w_m1[dts_pkg::VIDX_W-1:0]] <= 1'b1;
						depth_q <= depth_q + dts_pkg::VTX_W'(1);
						w_q <= dts_pkg::VTX_W'(1);
					end else begin
						w_q <= w_q + dts_pkg::VTX_W'(1);
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	// stack payload: written before read, no reset
	always_ff @(posedge clk) begin
		if (state_q == W_ROOT && !(root_q > vertex_limit) &&
				!visited_q[root_m1[dts_pkg::VIDX_W-1:0]]) begin
			stk_v_q[0] <= root_q;
		end
		if (state_q == W_SCAN && !scan_end && hit) begin
			stk_n_q[top_m[dts_pkg::VIDX_W-1:0]] <= w_q + dts_pkg::VTX_W'(1);
			stk_v_q[depth_q[dts_pkg::VIDX_W-1:0]] <= w_q;
		end
	end

endmodule

FILE: rtl/core/dts_order.sv
// Finish-order buffer and registered output that replays it in reverse.
module dts_order (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dts_pkg::dts_ctl_t            ctl,
	input  logic                         out_ready,
	output logic [dts_pkg::VTX_W-1:0]    vertex,
	output logic                         last,
	output logic                         out_valid,
	output logic                         idle
);

	typedef enum logic [1:0] {
		E_IDLE = 2'b01,
		E_EMIT = 2'b10
	} emit_state_t;

	emit_state_t state_q;
	logic [dts_pkg::VTX_W-1:0] fin_order_q [dts_pkg::MAX_VERTICES];
	logic [dts_pkg::VTX_W-1:0] count_q;
	logic [dts_pkg::VTX_W-1:0] idx_q;
	logic [dts_pkg::VTX_W-1:0] idx_m1;
	logic [dts_pkg::VTX_W-1:0] vertex_q;
	logic last_q;
	logic valid_q;
	logic load;

	assign idx_m1 = idx_q - dts_pkg::VTX_W'(1);
	assign load = (state_q == E_EMIT) && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			count_q <= '0;
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				count_q <= '0;
			end else if (ctl.fin_valid) begin
				count_q <= count_q + dts_pkg::VTX_W'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					if (ctl.done && count_q != '0) begin
						idx_q <= count_q;
						state_q <= E_EMIT;
					end
				end
				E_EMIT: begin
					if (load) begin
						idx_q <= idx_m1;
						if (idx_q == dts_pkg::VTX_W'(1)) begin
							state_q <= E_IDLE;
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin_valid) begin
			fin_order_q[count_q[dts_pkg::VIDX_W-1:0]] <= ctl.fin_vertex;
		end
		if (load) begin
			vertex_q <= fin_order_q[idx_m1[dts_pkg::VIDX_W-1:0]];
			last_q <= (idx_q == dts_pkg::VTX_W'(1));
		end
	end

	assign vertex = vertex_q;
	assign last = last_q;
	assign out_valid = valid_q;
	assign idle = (state_q == E_IDLE);

endmodule

FILE: rtl/core/dfs_topological_sort_unit.sv
// Top level of the DFS topological sort unit: ports, vertex count register, assertions.
//
// Usage: items enter on the in_valid/in_ready channel with fields opcode,
// from_vertex and to_vertex. An add beat sets one bit of a 16x16 adjacency
// matrix and a clear beat empties it; both give no result, so edges can
// stream in back to back. A sort beat runs a depth-first
// search from each unvisited vertex 1..n in ascending order and returns the
// reverse finishing order on vertex/last, one beat per vertex, last set on
// the final one. n is cfg_wr_data as written (reset 4), capped at 16; n of
// zero gives no result beats.
// Timing: the search tests one candidate neighbor per cycle on a single
// compare step; the replay then gives one beat per cycle as the receiver takes
// them. in_ready stays low from the sort beat until the last result has moved
// into the output register.
// A stalled receiver holds the output register and pauses the replay; the
// next item is accepted while the final result still waits there.
// Reset clears the graph, the marks, the count and all handshake state.
module dfs_topological_sort_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dts_pkg::OP_W-1:0]     opcode,
	input  logic [dts_pkg::VTX_W-1:0]    from_vertex,
	input  logic [dts_pkg::VTX_W-1:0]    to_vertex,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dts_pkg::VTX_W-1:0]    vertex,
	output logic                         last,
	input  logic                         cfg_wr_en,
	input  logic [dts_pkg::VTX_W-1:0]    cfg_wr_data
);

	logic [dts_pkg::VTX_W-1:0] vcount_q;
	logic [dts_pkg::VTX_W-1:0] n_eff;
	logic in_beat;
	logic walker_idle;
	logic order_idle;
	logic [dts_pkg::VIDX_W-1:0] adj_addr;
	logic [dts_pkg::MAX_VERTICES-1:0] adj_row;
	dts_pkg::dts_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= dts_pkg::VTX_W'(4);
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	// counts above the matrix size act as a full matrix
	assign n_eff = (vcount_q > dts_pkg::VTX_W'(dts_pkg::MAX_VERTICES)) ?
		dts_pkg::VTX_W'(dts_pkg::MAX_VERTICES) : vcount_q;

	assign in_ready = walker_idle && order_idle;
	assign in_beat = in_valid && in_ready;

	dts_adj u_adj (
		.clk         (clk),
		.arst_n      (arst_n),
		.add_en      (in_beat && opcode == dts_pkg::OP_ADD),
		.clear_en    (in_beat && opcode == dts_pkg::OP_CLEAR),
		.from_vertex (from_vertex),
		.to_vertex   (to_vertex),
		.rd_addr     (adj_addr),
		.rd_row      (adj_row)
	);

	dts_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_beat && opcode == dts_pkg::OP_SORT),
		.vertex_limit (n_eff),
		.adj_row      (adj_row),
		.adj_addr     (adj_addr),
		.ctl          (ctl),
		.idle         (walker_idle)
	);

	dts_order u_order (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.out_ready (out_ready),
		.vertex    (vertex),
		.last      (last),
		.out_valid (out_valid),
		.idle      (order_idle)
	);

	// a sort beat closes the input until the search and replay are done
	a_sort_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && opcode == dts_pkg::OP_SORT |=> !in_ready)
		else $error("input open right after a sort beat");

	// vertices finish only while a search is running
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin_valid |-> !walker_idle && !ctl.done)
		else $error("finish beat outside a search");

	// a new result appears only from an active replay
	a_out_from_replay: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!order_idle))
		else $error("result beat without replay");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the DFS topological sort unit: random stimulus, order predictor.
module tb_top;
	import dts_pkg::*;

	// Kinds of entries in the stimulus queue: a beat on the input channel,
	// a write of the vertex count, or a pause until every result is back.
	typedef enum logic [1:0] {
		STIM_BEAT,
		STIM_CFG,
		STIM_DRAIN
	} stim_kind_e;

	typedef struct {
		stim_kind_e       kind;
		opcode_t          op;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;
		logic [VTX_W-1:0] count;
	} stim_t;

	typedef struct packed {
		logic [VTX_W-1:0] vtx;
		logic             fin;
	} order_beat_t;

	// Cycles to hold off after the last result before a register write; a sort
	// with a zero vertex count yields no result but keeps the block busy briefly.
	localparam int SETTLE_CYCLES = 8;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     opcode = '0;
	logic [VTX_W-1:0]    from_vertex = '0;
	logic [VTX_W-1:0]    to_vertex = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VTX_W-1:0]    vertex;
	logic                last;
	logic                cfg_wr_en = 1'b0;
	logic [VTX_W-1:0]    cfg_wr_data = '0;

	stim_t       stim_q[$];
	order_beat_t topo_order_q[$];

	// Predictor state: adjacency rows (bit w-1 of row v-1 is edge v->w) and
	// the vertex count register as last written.
	logic [MAX_VERTICES-1:0] adj_rows[MAX_VERTICES];
	logic [VTX_W-1:0]        vtx_count;

	int  errors = 0;
	int  beats_in = 0;
	int  hold_cnt = 0;
	bit  in_taken = 1'b0;
	bit  calm;

	dfs_topological_sort_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.from_vertex(from_vertex),
		.to_vertex  (to_vertex),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.vertex     (vertex),
		.last       (last),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Turn off all idling on both sides for one stretch of input beats.
	assign calm = (beats_in >= 120) && (beats_in < 180);

	// Run the depth-first search on the predicted graph and queue the vertices
	// in reverse finishing order, the final one flagged. Roots and neighbors
	// are tried in ascending order; a visited target (self loop, back edge) is
	// skipped, and edges that leave 1..n are never followed.
	function automatic void predict_sort_order();
		int n;
		int depth;
		int top;
		int v;
		int w;
		int done_cnt;
		bit pushed;
		logic [MAX_VERTICES-1:0] seen;
		int stk_vtx[MAX_VERTICES];
		int stk_next[MAX_VERTICES];
		int fin_order[MAX_VERTICES];
		order_beat_t beat;
		n = (vtx_count > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_count);
		seen = '0;
		done_cnt = 0;
		for (int root = 1; root <= n; root++) begin
			if (!seen[root-1]) begin
				stk_vtx[0] = root;
				stk_next[0] = 1;
				seen[root-1] = 1'b1;
				depth = 1;
				while (depth > 0) begin
					top = depth - 1;
					v = stk_vtx[top];
					w = stk_next[top];
					pushed = 1'b0;
					while (w <= n && !pushed) begin
						if (adj_rows[v-1][w-1] && !seen[w-1]) begin
							// descend into the neighbor, resume after it later
							stk_next[top] = w + 1;
							stk_vtx[depth] = w;
							stk_next[depth] = 1;
							seen[w-1] = 1'b1;
							depth++;
							pushed = 1'b1;
						end else begin
							w++;
						end
					end
					if (!pushed) begin
						// all children finished: record and pop
						fin_order[done_cnt] = v;
						done_cnt++;
						depth--;
					end
				end
			end
		end
		for (int k = 0; k < done_cnt; k++) begin
			beat.vtx = fin_order[done_cnt-1-k];
			beat.fin = (k + 1 == done_cnt);
			topo_order_q.push_back(beat);
		end
	endfunction

	task automatic push_item(input opcode_t op, input int src, input int dst);
		stim_t s;
		s.kind = STIM_BEAT;
		s.op = op;
		s.src = src[VTX_W-1:0];
		s.dst = dst[VTX_W-1:0];
		s.count = '0;
		stim_q.push_back(s);
	endtask

	// A register write always follows a full drain and the hold-off.
	task automatic push_cfg(input int count);
		stim_t s;
		s.kind = STIM_DRAIN;
		s.op = OP_NONE;
		s.src = '0;
		s.dst = '0;
		s.count = '0;
		stim_q.push_back(s);
		s.kind = STIM_CFG;
		s.count = count[VTX_W-1:0];
		stim_q.push_back(s);
	endtask

	task automatic push_drain();
		stim_t s;
		s.kind = STIM_DRAIN;
		s.op = OP_NONE;
		s.src = '0;
		s.dst = '0;
		s.count = '0;
		stim_q.push_back(s);
	endtask

	// Sender: advance at the falling edge. Hold valid and payload until the
	// beat is taken, then either idle or present the next pending entry.
	always @(negedge clk) begin : send_side
		logic  valid_nx;
		logic  cfg_nx;
		stim_t head;
		if (arst_n) begin
			valid_nx = in_valid;
			cfg_nx = 1'b0;
			if (in_taken) begin
				in_taken = 1'b0;
				valid_nx = 1'b0;
			end
			if (!valid_nx) begin
				if (hold_cnt > 0) begin
					hold_cnt--;
				end else if (stim_q.size() != 0) begin
					head = stim_q[0];
					case (head.kind)
						STIM_BEAT: begin
							if (calm || $urandom_range(99) >= 19) begin
								opcode <= head.op;
								from_vertex <= head.src;
								to_vertex <= head.dst;
								valid_nx = 1'b1;
								void'(stim_q.pop_front());
							end
						end
						STIM_DRAIN: begin
							// hold until every expected result has come back
							if (topo_order_q.size() == 0) begin
								hold_cnt = SETTLE_CYCLES;
								void'(stim_q.pop_front());
							end
						end
						STIM_CFG: begin
							if (topo_order_q.size() == 0) begin
								cfg_wr_data <= head.count;
								cfg_nx = 1'b1;
								void'(stim_q.pop_front());
							end
						end
						default: ;
					endcase
				end
			end
			in_valid <= valid_nx;
			cfg_wr_en <= cfg_nx;
		end
	end

	// Receiver: stall at random, except in the calm stretch.
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= calm || ($urandom_range(99) >= 19);
	end

	// Monitor: sample at the rising edge. Check result beats against the
	// oldest expectation first, then fold register writes and input beats
	// into the predictor.
	always @(posedge clk) begin : watch_side
		order_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (topo_order_q.size() == 0) begin
					$display("%0t: unexpected result beat vertex %0d last %0d",
						$time, vertex, last);
					errors++;
				end else begin
					want = topo_order_q.pop_front();
					if (vertex !== want.vtx) begin
						$display("%0t: vertex expected %0d got %0d", $time, want.vtx, vertex);
						errors++;
					end
					if (last !== want.fin) begin
						$display("%0t: last expected %0d got %0d", $time, want.fin, last);
						errors++;
					end
				end
			end
			if (cfg_wr_en)
				vtx_count = cfg_wr_data;
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				beats_in++;
				case (opcode)
					OP_ADD: begin
						// drop edges with an end outside 1..MAX_VERTICES
						if (from_vertex >= 1 && from_vertex <= MAX_VERTICES &&
							to_vertex >= 1 && to_vertex <= MAX_VERTICES)
							adj_rows[from_vertex-1][to_vertex-1] = 1'b1;
					end
					OP_CLEAR: begin
						foreach (adj_rows[i])
							adj_rows[i] = '0;
					end
					OP_SORT: predict_sort_order();
					default: ;
				endcase
			end
		end
	end

	// Global watchdog.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : main_flow
		int made;
		int pick;
		int nv;
		int span;
		int nedges;
		int a;
		int b;
		int tmp;
		int guard;

		foreach (adj_rows[i])
			adj_rows[i] = '0;
		vtx_count = 5'd4;

		// Directed part, vertex count still at its reset value of four.
		push_item(OP_SORT, 0, 0);          // empty graph: plain descending order
		push_item(OP_ADD, 1, 2);
		push_item(OP_ADD, 2, 3);
		push_item(OP_ADD, 1, 3);
		push_item(OP_ADD, 3, 3);           // self loop
		push_item(OP_ADD, 4, 1);
		push_item(OP_ADD, 0, 2);           // zero source: dropped
		push_item(OP_ADD, 2, 0);           // zero target: dropped
		push_item(OP_ADD, 17, 1);          // above the vertex limit: dropped
		push_item(OP_ADD, 31, 31);
		push_item(OP_ADD, 1, 5);           // stored, but beyond the count
		push_item(OP_ADD, 5, 2);
		push_item(OP_NONE, 1, 4);          // unused opcode: no effect
		push_item(OP_SORT, 31, 31);
		push_item(OP_ADD, 3, 1);           // closes a cycle
		push_item(OP_ADD, 1, 2);           // duplicate edge
		push_item(OP_SORT, 0, 0);
		push_cfg(16);
		push_item(OP_ADD, 16, 1);
		push_item(OP_ADD, 1, 16);
		push_item(OP_ADD, 16, 16);
		push_item(OP_SORT, 16, 16);
		push_cfg(0);                       // zero count: sort yields nothing
		push_item(OP_SORT, 0, 0);
		push_cfg(31);                      // above the limit: acts as sixteen
		push_item(OP_SORT, 0, 0);
		push_item(OP_CLEAR, 31, 0);
		push_item(OP_SORT, 0, 0);
		push_cfg(1);
		push_item(OP_SORT, 0, 0);

		// Random part: per phase pick a count (mostly small), optionally
		// clear, load well-formed edges with some noise, then sort.
		made = 0;
		while (made < 250) begin
			pick = $urandom_range(99);
			if (pick < 10)
				nv = 16;
			else if (pick < 14)
				nv = 0;
			else if (pick < 18)
				nv = $urandom_range(31, 17);
			else if (pick < 22)
				nv = 1;
			else
				nv = $urandom_range(8, 2);
			span = (nv > MAX_VERTICES) ? MAX_VERTICES : ((nv == 0) ? 4 : nv);
			push_cfg(nv);
			if ($urandom_range(3) != 0) begin
				push_item(OP_CLEAR, $urandom_range(31), $urandom_range(31));
				made++;
			end
			nedges = $urandom_range(span + 4, 1);
			for (int e = 0; e < nedges; e++) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					a = $urandom_range(span, 1);
					b = $urandom_range(span, 1);
					// lean toward forward edges so most graphs stay acyclic
					if ($urandom_range(9) < 7 && a > b) begin
						tmp = a;
						a = b;
						b = tmp;
					end
					push_item(OP_ADD, a, b);
				end else if (pick < 90) begin
					push_item(OP_ADD, $urandom_range(31), $urandom_range(31));
				end else if (pick < 95) begin
					push_item(OP_ADD, $urandom_range(MAX_VERTICES, 1),
						$urandom_range(MAX_VERTICES, 1));
				end else begin
					push_item(OP_NONE, $urandom_range(31), $urandom_range(31));
				end
				made++;
			end
			push_item(OP_SORT, $urandom_range(31), $urandom_range(31));
			made++;
			// Sometimes extend the graph and sort again, with or without a pause.
			if ($urandom_range(4) == 0) begin
				if ($urandom_range(1) != 0)
					push_drain();
				push_item(OP_ADD, $urandom_range(span, 1), $urandom_range(span, 1));
				push_item(OP_SORT, $urandom_range(31), $urandom_range(31));
				made += 2;
			end
		end

		// Release reset away from the rising edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every entry to be sent, then for the results to drain.
		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		for (guard = 0; guard < 200000 && topo_order_q.size() != 0; guard++)
			@(posedge clk);
		if (topo_order_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, topo_order_q.size());
			errors++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
